// ===== sv/tbcm_pkg.sv =====
package tbcm_pkg;

  localparam int unsigned RoundCount = 32;
  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] TeaDelta = 32'h9e37_79b9;

  localparam int unsigned CfgIndexWidth = 3;

  localparam logic [CfgIndexWidth-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_IV_HIGH = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_IV_LOW = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_CHAINING_MODE = 3'd6;
  localparam logic [CfgIndexWidth-1:0] REG_DIRECTION = 3'd7;

  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CTR = 2'd2;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECB,
    KIND_CBC,
    KIND_CTR
  } kind_t;

  typedef struct packed {
    logic [31:0] key_word_0;
    logic [31:0] key_word_1;
    logic [31:0] key_word_2;
    logic [31:0] key_word_3;
    logic [31:0] iv_high;
    logic [31:0] iv_low;
    logic [1:0]  chaining_mode;
    logic        direction;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic        decrypt;
    logic        start;
    logic [31:0] data_left;
    logic [31:0] data_right;
    logic [63:0] counter;
  } cmd_t;

  function automatic logic [31:0] tea_mix(
    input logic [31:0] v,
    input logic [31:0] sum,
    input logic [31:0] ka,
    input logic [31:0] kb
  );
    tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

// ===== sv/tbcm_front.sv =====
module tbcm_front (
  input  logic                clk,
  input  logic                rst,
  input  tbcm_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic [31:0]         block_left,
  input  logic [31:0]         block_right,
  input  logic                start_of_message,
  input  logic                queue_full,
  output logic                in_stall,
  output logic                push,
  output tbcm_pkg::cmd_t      cmd
);

  logic [63:0] counter;
  logic [63:0] counter_next;
  logic [63:0] counter_use;
  tbcm_pkg::kind_t kind;

  always_comb begin
    unique case (cfg.chaining_mode)
      tbcm_pkg::MODE_CBC: kind = tbcm_pkg::KIND_CBC;
      tbcm_pkg::MODE_CTR: kind = tbcm_pkg::KIND_CTR;
      default:            kind = tbcm_pkg::KIND_ECB;
    endcase
  end

  assign in_stall = queue_full;
  assign push = in_valid && !queue_full;

  // counter value for this request, restarted from the iv on start
  assign counter_use = start_of_message ? {cfg.iv_high, cfg.iv_low} : counter;
  assign counter_next = (kind == tbcm_pkg::KIND_CTR) ? counter_use + 64'd1 : counter_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (push) begin
      counter <= counter_next;
    end
  end

  always_comb begin
    cmd.kind = kind;
    cmd.decrypt = (kind != tbcm_pkg::KIND_CTR) && (cfg.direction == tbcm_pkg::DIR_DECRYPT);
    cmd.start = start_of_message;
    cmd.data_left = block_left;
    cmd.data_right = block_right;
    cmd.counter = counter_use;
  end

endmodule

// ===== sv/tbcm_queue.sv =====
module tbcm_queue #(
  parameter int unsigned DEPTH = tbcm_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tbcm_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output tbcm_pkg::cmd_t head_cmd
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
  localparam logic [CountWidth-1:0] CountFull = CountWidth'(DEPTH);

  tbcm_pkg::cmd_t entries [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CountWidth-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CountFull);
  assign not_empty = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CountWidth'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== sv/tbcm_back.sv =====
module tbcm_back #(
  parameter int unsigned ROUND_COUNT = tbcm_pkg::RoundCount
) (
  input  logic           clk,
  input  logic           rst,
  input  tbcm_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  tbcm_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    result_left,
  output logic [31:0]    result_right
);

  localparam int unsigned RcWidth = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RcWidth-1:0] RoundLast = RcWidth'(ROUND_COUNT - 1);
  localparam logic [63:0] SumProduct = 64'(tbcm_pkg::TeaDelta) * 64'(ROUND_COUNT);
  localparam logic [31:0] SumDecInit = SumProduct[31:0];

  logic busy;
  logic decrypt;
  logic cbc_encrypt;
  logic [RcWidth-1:0] round;
  logic [31:0] l;
  logic [31:0] r;
  logic [31:0] sum;
  logic [31:0] mask_left;
  logic [31:0] mask_right;
  logic [31:0] chain_high;
  logic [31:0] chain_low;

  logic [31:0] chain_use_high;
  logic [31:0] chain_use_low;
  logic [31:0] sum_enc;
  logic [31:0] l_enc;
  logic [31:0] r_enc;
  logic [31:0] l_dec;
  logic [31:0] r_dec;
  logic [31:0] l_next;
  logic [31:0] r_next;
  logic [31:0] sum_next;
  logic [31:0] load_left;
  logic [31:0] load_right;
  logic [31:0] load_mask_left;
  logic [31:0] load_mask_right;
  logic last_round;
  logic slot_free;
  logic advance;
  logic finish;
  logic load;

  assign chain_use_high = cmd.start ? cfg.iv_high : chain_high;
  assign chain_use_low = cmd.start ? cfg.iv_low : chain_low;

  // one tea round, either direction
  always_comb begin
    sum_enc = sum + tbcm_pkg::TeaDelta;
    l_enc = l + tbcm_pkg::tea_mix(r, sum_enc, cfg.key_word_0, cfg.key_word_1);
    r_enc = r + tbcm_pkg::tea_mix(l_enc, sum_enc, cfg.key_word_2, cfg.key_word_3);
    r_dec = r - tbcm_pkg::tea_mix(l, sum, cfg.key_word_2, cfg.key_word_3);
    l_dec = l - tbcm_pkg::tea_mix(r_dec, sum, cfg.key_word_0, cfg.key_word_1);
    l_next = decrypt ? l_dec : l_enc;
    r_next = decrypt ? r_dec : r_enc;
    sum_next = decrypt ? sum - tbcm_pkg::TeaDelta : sum_enc;
  end

  // engine input and output whitening per mode
  always_comb begin
    unique case (cmd.kind)
      tbcm_pkg::KIND_CBC: begin
        if (cmd.decrypt) begin
          load_left = cmd.data_left;
          load_right = cmd.data_right;
          load_mask_left = chain_use_high;
          load_mask_right = chain_use_low;
        end else begin
          load_left = cmd.data_left ^ chain_use_high;
          load_right = cmd.data_right ^ chain_use_low;
          load_mask_left = '0;
          load_mask_right = '0;
        end
      end
      tbcm_pkg::KIND_CTR: begin
        load_left = cmd.counter[63:32];
        load_right = cmd.counter[31:0];
        load_mask_left = cmd.data_left;
        load_mask_right = cmd.data_right;
      end
      default: begin
        load_left = cmd.data_left;
        load_right = cmd.data_right;
        load_mask_left = '0;
        load_mask_right = '0;
      end
    endcase
  end

  assign last_round = (round == RoundLast);
  assign slot_free = !out_valid || !out_stall;
  assign advance = busy && (!last_round || slot_free);
  assign finish = advance && last_round;
  assign load = !busy && cmd_valid;
  assign cmd_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_high <= '0;
      chain_low <= '0;
    end else if (load) begin
      if (cmd.kind == tbcm_pkg::KIND_CBC && cmd.decrypt) begin
        chain_high <= cmd.data_left;
        chain_low <= cmd.data_right;
      end else if (cmd.start) begin
        chain_high <= cfg.iv_high;
        chain_low <= cfg.iv_low;
      end
    end else if (finish && cbc_encrypt) begin
      chain_high <= l_next;
      chain_low <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      decrypt <= cmd.decrypt;
      cbc_encrypt <= (cmd.kind == tbcm_pkg::KIND_CBC) && !cmd.decrypt;
      round <= '0;
      l <= load_left;
      r <= load_right;
      sum <= cmd.decrypt ? SumDecInit : '0;
      mask_left <= load_mask_left;
      mask_right <= load_mask_right;
    end else if (advance) begin
      round <= round + RcWidth'(1);
      l <= l_next;
      r <= r_next;
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_left <= l_next ^ mask_left;
      result_right <= r_next ^ mask_right;
    end
  end

endmodule

// ===== sv/tea_block_cipher_modes_unit.sv =====
// channel    direction  handshake             payload
// in         request    in_valid / in_stall   block_left, block_right, start_of_message
// out        result     out_valid / out_stall result_left, result_right
// cfg        write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// each request passes the round engine as one load step, then its tea rounds,
// one per cycle unless a stalled result holds the last round; the engine takes
// the next request from the queue only once its last round is done.
// a small request queue lets input be taken while the engine works and while a
// finished result waits in the output register.
// rst is synchronous; it clears config, chain value, counter and all valids.
// a stalled result holds the engine on its last round; a full queue raises in_stall.
module tea_block_cipher_modes_unit #(
  parameter int unsigned ROUND_COUNT = tbcm_pkg::RoundCount,
  parameter int unsigned QUEUE_DEPTH = tbcm_pkg::QueueDepth
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [31:0]                        block_left,
  input  logic [31:0]                        block_right,
  input  logic                               start_of_message,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        result_left,
  output logic [31:0]                        result_right,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tbcm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [31:0]                        cfg_data
);

  tbcm_pkg::cfg_t cfg;
  tbcm_pkg::cmd_t push_cmd;
  tbcm_pkg::cmd_t head_cmd;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbcm_pkg::REG_KEY_WORD_0:    cfg.key_word_0 <= cfg_data;
        tbcm_pkg::REG_KEY_WORD_1:    cfg.key_word_1 <= cfg_data;
        tbcm_pkg::REG_KEY_WORD_2:    cfg.key_word_2 <= cfg_data;
        tbcm_pkg::REG_KEY_WORD_3:    cfg.key_word_3 <= cfg_data;
        tbcm_pkg::REG_IV_HIGH:       cfg.iv_high <= cfg_data;
        tbcm_pkg::REG_IV_LOW:        cfg.iv_low <= cfg_data;
        tbcm_pkg::REG_CHAINING_MODE: cfg.chaining_mode <= cfg_data[1:0];
        tbcm_pkg::REG_DIRECTION:     cfg.direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tbcm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .block_left       (block_left),
    .block_right      (block_right),
    .start_of_message (start_of_message),
    .queue_full       (queue_full),
    .in_stall         (in_stall),
    .push             (push),
    .cmd              (push_cmd)
  );

  tbcm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head_cmd  (head_cmd)
  );

  tbcm_back #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (queue_not_empty),
    .cmd          (head_cmd),
    .cmd_pop      (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_left  (result_left),
    .result_right (result_right)
  );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import tbcm_pkg::*;

  localparam logic [1:0] MODE_ALIAS_ECB = 2'd3;

  localparam logic [1:0] KEYS_ZERO = 2'd0;
  localparam logic [1:0] KEYS_ONES = 2'd1;
  localparam logic [1:0] KEYS_MIXED = 2'd2;

  localparam int RandomTarget = 1900;
  localparam int DirRows = 25;
  localparam int MaxReports = 200;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
  } block_t;

  typedef struct packed {
    logic [1:0]  keyset;
    logic [1:0]  mode;
    logic        dir;
    logic        start;
    logic [31:0] left;
    logic [31:0] right;
  } dir_row_t;

  dir_row_t dir_rows [DirRows] = '{
    '{KEYS_ZERO,  MODE_ECB,       DIR_ENCRYPT, 1'b0, 32'h0000_0000, 32'h0000_0000},
    '{KEYS_ZERO,  MODE_ECB,       DIR_ENCRYPT, 1'b0, 32'hffff_ffff, 32'hffff_ffff},
    '{KEYS_ZERO,  MODE_ECB,       DIR_ENCRYPT, 1'b1, 32'h8000_0000, 32'h0000_0001},
    '{KEYS_ZERO,  MODE_ECB,       DIR_DECRYPT, 1'b0, 32'h0000_0000, 32'h0000_0000},
    '{KEYS_ZERO,  MODE_ECB,       DIR_DECRYPT, 1'b0, 32'hffff_ffff, 32'hffff_ffff},
    // chain and counter still zero, no start yet in these modes
    '{KEYS_ZERO,  MODE_CBC,       DIR_ENCRYPT, 1'b0, 32'h1234_5678, 32'h9abc_def0},
    '{KEYS_ZERO,  MODE_CTR,       DIR_ENCRYPT, 1'b0, 32'h0000_0000, 32'h0000_0000},
    '{KEYS_ZERO,  MODE_CTR,       DIR_ENCRYPT, 1'b0, 32'hffff_ffff, 32'hffff_ffff},
    // counter at all ones, then wraps to zero
    '{KEYS_ONES,  MODE_CTR,       DIR_ENCRYPT, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{KEYS_ONES,  MODE_CTR,       DIR_ENCRYPT, 1'b0, 32'h0000_0000, 32'h0000_0000},
    '{KEYS_ONES,  MODE_CTR,       DIR_DECRYPT, 1'b0, 32'ha5a5_a5a5, 32'h5a5a_5a5a},
    '{KEYS_ONES,  MODE_ECB,       DIR_ENCRYPT, 1'b0, 32'hffff_ffff, 32'hffff_ffff},
    '{KEYS_ONES,  MODE_ECB,       DIR_DECRYPT, 1'b0, 32'hffff_ffff, 32'hffff_ffff},
    '{KEYS_MIXED, MODE_CBC,       DIR_ENCRYPT, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{KEYS_MIXED, MODE_CBC,       DIR_ENCRYPT, 1'b0, 32'h1111_1111, 32'h2222_2222},
    '{KEYS_MIXED, MODE_CBC,       DIR_ENCRYPT, 1'b0, 32'hffff_ffff, 32'hffff_ffff},
    '{KEYS_MIXED, MODE_CBC,       DIR_DECRYPT, 1'b1, 32'h0102_0304, 32'h0506_0708},
    '{KEYS_MIXED, MODE_CBC,       DIR_DECRYPT, 1'b0, 32'hffff_ffff, 32'h0000_0000},
    '{KEYS_MIXED, MODE_ALIAS_ECB, DIR_ENCRYPT, 1'b0, 32'h0bad_cafe, 32'h0000_ffff},
    '{KEYS_MIXED, MODE_ALIAS_ECB, DIR_DECRYPT, 1'b0, 32'h0bad_cafe, 32'h0000_ffff},
    // mode switches inside one message, each mode on its own state
    '{KEYS_MIXED, MODE_CTR,       DIR_ENCRYPT, 1'b1, 32'h1357_9bdf, 32'h2468_ace0},
    '{KEYS_MIXED, MODE_CBC,       DIR_ENCRYPT, 1'b0, 32'h0000_0000, 32'h0000_0000},
    '{KEYS_MIXED, MODE_CTR,       DIR_ENCRYPT, 1'b0, 32'h0000_0000, 32'h0000_0000},
    '{KEYS_MIXED, MODE_ECB,       DIR_ENCRYPT, 1'b1, 32'hdead_beef, 32'hcafe_f00d},
    '{KEYS_MIXED, MODE_CBC,       DIR_DECRYPT, 1'b0, 32'h0000_0000, 32'h0000_0000}
  };

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [31:0]              block_left;
  logic [31:0]              block_right;
  logic                     start_of_message;
  logic                     out_valid;
  logic                     out_stall;
  logic [31:0]              result_left;
  logic [31:0]              result_right;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [31:0]              cfg_data;

  // shadow of the configuration and the chaining state
  logic [31:0] key_sh [4];
  logic [31:0] iv_hi_sh;
  logic [31:0] iv_lo_sh;
  logic [1:0]  mode_sh;
  logic        dir_sh;
  logic [63:0] chain_q;
  logic [63:0] counter_q;

  block_t expected_blocks [$];

  int errors;
  int reports;
  int results_seen;
  int requests_sent;
  int random_sent;
  int settings_loaded;
  int burst_left;
  bit steady;

  tea_block_cipher_modes_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .block_left       (block_left),
    .block_right      (block_right),
    .start_of_message (start_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_left      (result_left),
    .result_right     (result_right),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [31:0] round_mix(input logic [31:0] v, input logic [31:0] s,
                                            input logic [31:0] ka, input logic [31:0] kb);
    return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

  function automatic logic [63:0] tea_forward(input logic [63:0] blk);
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] s;
    l = blk[63:32];
    r = blk[31:0];
    s = '0;
    for (int i = 0; i < RoundCount; i++) begin
      s = s + TeaDelta;
      l = l + round_mix(r, s, key_sh[0], key_sh[1]);
      r = r + round_mix(l, s, key_sh[2], key_sh[3]);
    end
    return {l, r};
  endfunction

  function automatic logic [63:0] tea_inverse(input logic [63:0] blk);
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] s;
    l = blk[63:32];
    r = blk[31:0];
    s = TeaDelta * RoundCount;
    for (int i = 0; i < RoundCount; i++) begin
      r = r - round_mix(l, s, key_sh[2], key_sh[3]);
      l = l - round_mix(r, s, key_sh[0], key_sh[1]);
      s = s - TeaDelta;
    end
    return {l, r};
  endfunction

  function automatic logic [63:0] predict_block(input logic [31:0] bl, input logic [31:0] br,
                                                input logic st);
    logic [63:0] res;
    if (st) begin
      chain_q = {iv_hi_sh, iv_lo_sh};
      counter_q = {iv_hi_sh, iv_lo_sh};
    end
    if (mode_sh == MODE_CBC) begin
      if (dir_sh == DIR_ENCRYPT) begin
        res = tea_forward({bl, br} ^ chain_q);
        chain_q = res;
      end else begin
        res = tea_inverse({bl, br}) ^ chain_q;
        chain_q = {bl, br};
      end
    end else if (mode_sh == MODE_CTR) begin
      res = tea_forward(counter_q) ^ {bl, br};
      counter_q = counter_q + 64'd1;
    end else begin
      res = (dir_sh == DIR_ENCRYPT) ? tea_forward({bl, br}) : tea_inverse({bl, br});
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'h0000_0000;
      1: w = 32'hffff_ffff;
      2: w = 32'h1 << $urandom_range(0, 31);
      3: w = ~(32'h1 << $urandom_range(0, 31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY_WORD_0: key_sh[0] = val;
      REG_KEY_WORD_1: key_sh[1] = val;
      REG_KEY_WORD_2: key_sh[2] = val;
      REG_KEY_WORD_3: key_sh[3] = val;
      REG_IV_HIGH: iv_hi_sh = val;
      REG_IV_LOW: iv_lo_sh = val;
      REG_CHAINING_MODE: mode_sh = val[1:0];
      REG_DIRECTION: dir_sh = val[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] k0, input logic [31:0] k1,
                               input logic [31:0] k2, input logic [31:0] k3,
                               input logic [31:0] ivh, input logic [31:0] ivl,
                               input logic [1:0] mode, input logic dir);
    write_reg(REG_KEY_WORD_0, k0);
    write_reg(REG_KEY_WORD_1, k1);
    write_reg(REG_KEY_WORD_2, k2);
    write_reg(REG_KEY_WORD_3, k3);
    write_reg(REG_IV_HIGH, ivh);
    write_reg(REG_IV_LOW, ivl);
    write_reg(REG_CHAINING_MODE, {30'd0, mode});
    write_reg(REG_DIRECTION, {31'd0, dir});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
  endtask

  task automatic send_block(input logic [31:0] l, input logic [31:0] r, input logic st);
    int gap;
    logic [63:0] res;
    block_t want;
    gap = 0;
    if (!steady) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    block_left <= l;
    block_right <= r;
    start_of_message <= st;
    do @(posedge clk); while (in_stall);
    res = predict_block(l, r, st);
    want.left = res[63:32];
    want.right = res[31:0];
    expected_blocks.insert(expected_blocks.size(), want);
    requests_sent++;
  endtask

  // receiver stall pattern, switching style every so often
  initial begin
    int style;
    int style_cycles;
    int hold;
    bit level;
    style = 0;
    style_cycles = 0;
    hold = 0;
    level = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (style_cycles == 0) begin
        style = $urandom_range(0, 3);
        style_cycles = $urandom_range(20, 200);
      end
      style_cycles--;
      case (style)
        0: level = 1'b0;
        1: level = ($urandom_range(0, 3) == 0);
        2: begin
          if (hold == 0) begin
            level = ~level;
            hold = level ? $urandom_range(1, 40) : $urandom_range(1, 10);
          end
          hold--;
        end
        default: level = ~level;
      endcase
      out_stall <= level;
    end
  end

  always @(posedge clk) begin
    block_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        errors++;
        if (reports < MaxReports) begin
          $error("result with no pending request: %h %h", result_left, result_right);
          reports++;
        end
      end else begin
        want = expected_blocks.pop_front();
        results_seen++;
        if (result_left !== want.left) begin
          errors++;
          if (reports < MaxReports) begin
            $error("result_left expected %h actual %h", want.left, result_left);
            reports++;
          end
        end
        if (result_right !== want.right) begin
          errors++;
          if (reports < MaxReports) begin
            $error("result_right expected %h actual %h", want.right, result_right);
            reports++;
          end
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    logic [1:0] cur_set;
    logic [31:0] k [4];
    logic [31:0] ivh;
    logic [31:0] ivl;
    logic [1:0] mode;
    logic st;
    int phase;
    int phase_len;
    int msg_left;

    errors = 0;
    reports = 0;
    results_seen = 0;
    requests_sent = 0;
    random_sent = 0;
    settings_loaded = 0;
    burst_left = 0;
    steady = 1'b0;
    for (int i = 0; i < 4; i++) key_sh[i] = '0;
    iv_hi_sh = '0;
    iv_lo_sh = '0;
    mode_sh = MODE_ECB;
    dir_sh = DIR_ENCRYPT;
    chain_q = '0;
    counter_q = '0;
    cur_set = KEYS_ZERO;

    rst <= 1'b1;
    in_valid <= 1'b0;
    block_left <= '0;
    block_right <= '0;
    start_of_message <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DirRows; n++) begin
      row = dir_rows[n];
      if (row.keyset != cur_set || row.mode != mode_sh || row.dir != dir_sh) begin
        wait_idle();
        case (row.keyset)
          KEYS_ONES: begin
            k = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
            ivh = 32'hffff_ffff;
            ivl = 32'hffff_ffff;
          end
          KEYS_MIXED: begin
            k = '{32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210};
            ivh = 32'hdead_beef;
            ivl = 32'h0bad_f00d;
          end
          default: begin
            k = '{32'h0, 32'h0, 32'h0, 32'h0};
            ivh = 32'h0;
            ivl = 32'h0;
          end
        endcase
        load_settings(k[0], k[1], k[2], k[3], ivh, ivl, row.mode, row.dir);
        cur_set = row.keyset;
      end
      send_block(row.left, row.right, row.start);
    end

    phase = 0;
    while (random_sent < RandomTarget) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: k = '{32'h0, 32'h0, 32'h0, 32'h0};
        1: k = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        default: k = '{pick_word(), pick_word(), pick_word(), pick_word()};
      endcase
      case ($urandom_range(0, 7))
        0: begin
          ivh = 32'h0;
          ivl = 32'h0;
        end
        1: begin
          ivh = 32'hffff_ffff;
          ivl = 32'hffff_ffff;
        end
        // low half close to its carry into the high half
        2: begin
          ivh = $urandom;
          ivl = 32'hffff_ffff - $urandom_range(0, 7);
        end
        3: begin
          ivh = 32'hffff_ffff;
          ivl = 32'hffff_ffff - $urandom_range(0, 7);
        end
        default: begin
          ivh = $urandom;
          ivl = $urandom;
        end
      endcase
      mode = ($urandom_range(0, 15) == 0) ? MODE_ALIAS_ECB : 2'($urandom_range(0, 2));
      if (phase == 0) begin
        k = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        ivh = 32'hffff_ffff;
        ivl = 32'hffff_fffc;
        mode = MODE_CTR;
      end else if (phase == 1) begin
        k = '{32'h0, 32'h0, 32'h0, 32'h0};
        ivh = 32'h0;
        ivl = 32'h0;
        mode = MODE_CBC;
      end
      load_settings(k[0], k[1], k[2], k[3], ivh, ivl, mode, 1'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 110);
      // sometimes carry on the message of the previous setting
      msg_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      repeat (phase_len) begin
        if (msg_left == 0) begin
          st = 1'b1;
          msg_left = $urandom_range(1, 12);
        end else begin
          st = 1'b0;
        end
        msg_left--;
        if ($urandom_range(0, 11) == 0) st = ~st;
        send_block(pick_word(), pick_word(), st);
        random_sent++;
      end
      phase++;
    end

    steady = 1'b0;
    wait_idle();
    repeat (RoundCount + 8) @(posedge clk);

    $display("sent %0d requests (%0d random) under %0d register settings", requests_sent,
             random_sent, settings_loaded);
    $display("checked %0d results across ecb, cbc and ctr in both directions", results_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== tea_block_cipher_modes_unit.f =====
sv/tbcm_pkg.sv
sv/tbcm_front.sv
sv/tbcm_queue.sv
sv/tbcm_back.sv
sv/tea_block_cipher_modes_unit.sv
tb/sv/tb.sv
